/* src/msc_pkg.sv */
`default_nettype none
package msc_pkg;

	// Switch port geometry
	localparam int PORT_BITS = 8;
	localparam int IDX_W     = 3;
	localparam int CNT_W     = 8;

	// Stream word widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;

	// Configuration register map
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 1'd1;

	localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 8'd5;
	localparam logic [CFG_DATA_W-1:0] ENABLE_RST    = 8'hFF;

	// Sample modes carried in s_tuser
	localparam logic MODE_DEBOUNCE = 1'b0;
	localparam logic MODE_SNAPSHOT = 1'b1;

	typedef logic [CNT_W-1:0] cnt_t;

endpackage
`default_nettype wire

/* src/multi_switch_counter_debounce.sv */
`default_nettype none
// Counter-based debounce of an 8-bit switch port. Each input word is one
// polled sample: s_tdata holds the pin levels, s_tuser selects debounce (0)
// or snapshot (1). A snapshot loads the stable levels and emits nothing. A
// debounce sample runs every enabled bit's counter and emits one output word
// per switch whose stable level flips, in ascending bit order, with m_tlast
// on the final one of that sample. Rate: a sample is registered, then
// evaluated combinationally once the event buffer is free; a sample that
// causes no event leaves the buffer empty, and one that causes k events
// holds it until all k have moved to the output register, one per cycle
// while m_tready does not stall the output. The event buffer is the limiting
// unit. Registers take effect between samples: threshold 0 acts as 1, and
// the counters saturate at 255.
module multi_switch_counter_debounce
	import msc_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	// configuration write channel
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	// sample stream
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire [IN_DATA_W-1:0]   s_tdata,   // [7:0] pins
	input  wire                   s_tuser,   // [0] mode
	// change event stream
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] switch_index, [3] new_level, [7:4] zero
	output logic                  m_tlast
);

	// Config registers
	logic [CFG_DATA_W-1:0] threshold_q;
	logic [PORT_BITS-1:0]  enable_q;

	// Input stage
	logic                 valid_s1;
	logic                 mode_s1;
	logic [PORT_BITS-1:0] pins_s1;

	// Debounce state
	logic [PORT_BITS-1:0] stable_q;
	cnt_t                 cnt_q [PORT_BITS];

	// Event buffer: pending change bits and their new levels
	logic [PORT_BITS-1:0] pend_mask_q;
	logic [PORT_BITS-1:0] pend_lvl_q;

	// Output register
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_lvl_q;
	logic             out_last_q;

	logic                 pend_free;
	logic                 eval;
	logic [CNT_W-1:0]     thr_eff;
	logic [PORT_BITS-1:0] evt_mask;
	cnt_t                 cnt_nxt [PORT_BITS];
	logic                 out_load;
	logic [IDX_W-1:0]     pick_idx;
	logic [PORT_BITS-1:0] pick_bit;
	logic [PORT_BITS-1:0] pend_rest;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			enable_q    <= ENABLE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_ENABLE:    enable_q    <= cfg_data[PORT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 is evaluated once the event buffer is empty or hands out its last word
	assign pend_free = (pend_mask_q == '0) || (out_load && (pend_rest == '0));
	assign eval      = valid_s1 && pend_free;
	assign s_tready  = !valid_s1 || pend_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			pins_s1 <= s_tdata[PORT_BITS-1:0];
		end
	end

	// Per-bit counter update and flip detection
	assign thr_eff = (threshold_q == '0) ? CNT_W'(1) : threshold_q;

	always_comb begin
		for (int i = 0; i < PORT_BITS; i++) begin
			cnt_nxt[i]  = cnt_q[i];
			evt_mask[i] = 1'b0;
			if (enable_q[i]) begin
				if (pins_s1[i] == stable_q[i]) begin
					cnt_nxt[i] = '0;
				end else begin
					if (cnt_q[i] != '1)
						cnt_nxt[i] = cnt_q[i] + CNT_W'(1);
					if (cnt_nxt[i] >= thr_eff) begin
						cnt_nxt[i]  = '0;
						evt_mask[i] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			for (int i = 0; i < PORT_BITS; i++)
				cnt_q[i] <= '0;
		end else if (eval) begin
			if (mode_s1 == MODE_SNAPSHOT) begin
				stable_q <= pins_s1;
			end else begin
				stable_q <= (stable_q & ~evt_mask) | (pins_s1 & evt_mask);
				for (int i = 0; i < PORT_BITS; i++)
					cnt_q[i] <= cnt_nxt[i];
			end
		end
	end

	// Lowest pending event goes next
	always_comb begin
		pick_idx = '0;
		for (int i = PORT_BITS - 1; i >= 0; i--) begin
			if (pend_mask_q[i])
				pick_idx = IDX_W'(i);
		end
	end

	assign pick_bit  = pend_mask_q & (~pend_mask_q + PORT_BITS'(1));
	assign pend_rest = pend_mask_q & ~pick_bit;
	assign out_load  = (pend_mask_q != '0) && (!out_valid_q || m_tready);

	// Event buffer; a new sample refills it as the last word leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
		end else if (eval) begin
			pend_mask_q <= (mode_s1 == MODE_DEBOUNCE) ? evt_mask : '0;
		end else if (out_load) begin
			pend_mask_q <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (eval)
			pend_lvl_q <= pins_s1;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= pick_idx;
			out_lvl_q  <= pend_lvl_q[pick_idx];
			out_last_q <= (pend_rest == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(OUT_DATA_W - IDX_W - 1)'(0), out_lvl_q, out_idx_q};

endmodule
`default_nettype wire

/* src/msc_checker.sv */
`default_nettype none
module msc_checker
	import msc_pkg::*;
(
	input wire                  clk,
	input wire                  arst_n,
	input wire                  cfg_ready,
	input wire                  s_tready,
	input wire                  m_tvalid,
	input wire                  m_tready,
	input wire [OUT_DATA_W-1:0] m_tdata,
	input wire                  m_tlast
);

	// Stalled event word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("event word changed while stalled");

	// Pad bits of the event word stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:IDX_W+1] == '0)
		else $error("event word pad bits not zero");

	// A non-final event is followed at once by the next one of its sample
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("event run broke before last");

	// Back-pressure on samples only while events are waiting to drain
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> m_tvalid)
		else $error("sample input stalled with no events pending");

	// Config port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind multi_switch_counter_debounce msc_checker u_msc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast)
);
`default_nettype wire

/* sim/tb_multi_switch_counter_debounce.sv */
`timescale 1ns / 100ps
module tb_multi_switch_counter_debounce;
	import msc_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 80;
	localparam int MAX_REPORTS   = 10;

	// one expected change event
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             level;
		logic             last;
	} change_t;

	// debounce predictor plus queue of expected change words
	class debounce_scoreboard;
		logic [CFG_DATA_W-1:0] threshold;
		logic [PORT_BITS-1:0]  enable;
		logic [PORT_BITS-1:0]  levels;
		cnt_t                  counts [PORT_BITS];
		change_t               changes [$];
		int                    errors;

		function new();
			threshold = THRESHOLD_RST;
			enable    = ENABLE_RST;
			levels    = '0;
			foreach (counts[i]) counts[i] = '0;
			errors    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_THRESHOLD: threshold = data;
				REG_ENABLE:    enable = data;
				default: ;
			endcase
		endfunction

		// run one accepted sample through the counters
		function void note_sample(logic mode, logic [PORT_BITS-1:0] pins);
			change_t found [PORT_BITS];
			int      n;
			cnt_t    limit;
			n = 0;
			limit = (threshold == '0) ? cnt_t'(1) : cnt_t'(threshold);
			if (mode == MODE_SNAPSHOT) begin
				levels = pins;
				return;
			end
			for (int i = 0; i < PORT_BITS; i++) begin
				if (enable[i]) begin
					if (pins[i] == levels[i]) begin
						counts[i] = '0;
					end else begin
						if (counts[i] != '1)
							counts[i] = counts[i] + 1'b1;
						if (counts[i] >= limit) begin
							levels[i] = pins[i];
							counts[i] = '0;
							found[n] = '{idx: IDX_W'(i), level: pins[i], last: 1'b0};
							n++;
						end
					end
				end
			end
			if (n > 0)
				found[n-1].last = 1'b1;
			for (int k = 0; k < n; k++)
				changes.push_back(found[k]);
		endfunction

		function void report(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%s", what);
		endfunction

		// compare one accepted output word with the oldest expectation
		function void check_event(logic [OUT_DATA_W-1:0] word, logic last);
			change_t want;
			if (changes.size() == 0) begin
				report($sformatf("unexpected change word: index %0d level %0d last %0d",
					word[IDX_W-1:0], word[IDX_W], last));
				return;
			end
			want = changes.pop_front();
			if (word[IDX_W-1:0] !== want.idx || word[IDX_W] !== want.level ||
				last !== want.last || word[OUT_DATA_W-1:IDX_W+1] !== '0) begin
				report($sformatf({"change mismatch: expected index %0d level %0d last %0d, ",
					"got index %0d level %0d last %0d pad %h"},
					want.idx, want.level, want.last,
					word[IDX_W-1:0], word[IDX_W], last, word[OUT_DATA_W-1:IDX_W+1]));
			end
		endfunction

		function int pending();
			return changes.size();
		endfunction

		function void flush_leftover();
			change_t want;
			while (changes.size() != 0) begin
				want = changes.pop_front();
				report($sformatf("missing change word: index %0d level %0d last %0d",
					want.idx, want.level, want.last));
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // [7:0] pins
	logic                  s_tuser;   // [0] mode
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // [2:0] switch_index, [3] new_level, [7:4] zero
	logic                  m_tlast;

	debounce_scoreboard book;
	bit                 idle_on;
	int                 hold_ticket;
	int                 run_hint;
	int                 quiet_cycles;

	multi_switch_counter_debounce DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// change word receiver: random stalls, plus a long hold-off on request
	initial begin
		int served;
		served = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ticket != served) begin
				served = hold_ticket;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// check every accepted change word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_event(m_tdata, m_tlast);
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_sample(input logic mode, input logic [PORT_BITS-1:0] pins);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pins;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		book.note_sample(mode, pins);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		book.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering samples and let every expected change come out
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] en);
		settle();
		cfg_write(REG_THRESHOLD, thr);
		cfg_write(REG_ENABLE, en);
		run_hint = (thr == 0) ? 1 : ((thr > 8) ? 8 : int'(thr));
	endtask

	// runs toward a random target level, with single-bit noise and snapshots
	task automatic run_bursts(input int samples);
		int                   sent;
		int                   len;
		logic [PORT_BITS-1:0] target;
		logic [PORT_BITS-1:0] pins;
		sent = 0;
		while (sent < samples) begin
			target = PORT_BITS'($urandom);
			if ($urandom_range(0, 11) == 0) begin
				send_sample(MODE_SNAPSHOT, target);
				sent++;
			end else begin
				len = $urandom_range(1, run_hint + 2);
				repeat (len) begin
					pins = target;
					if ($urandom_range(0, 7) == 0)
						pins = pins ^ (PORT_BITS'(1) << $urandom_range(0, PORT_BITS - 1));
					send_sample(MODE_DEBOUNCE, pins);
					sent++;
				end
			end
		end
	endtask

	initial begin
		book         = new();
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = MODE_DEBOUNCE;
		idle_on      = 1'b1;
		hold_ticket  = 0;
		run_hint     = 5;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: snapshots, full-port flips, a bounce that clears counters
		send_sample(MODE_SNAPSHOT, 8'hFF);
		send_sample(MODE_SNAPSHOT, 8'h00);
		repeat (5) send_sample(MODE_DEBOUNCE, 8'hFF);
		repeat (4) send_sample(MODE_DEBOUNCE, 8'h00);
		send_sample(MODE_DEBOUNCE, 8'hFF);
		repeat (5) send_sample(MODE_DEBOUNCE, 8'h00);
		send_sample(MODE_SNAPSHOT, 8'h5A);
		send_sample(MODE_DEBOUNCE, 8'h5A);
		repeat (5) send_sample(MODE_DEBOUNCE, 8'hA5);

		// threshold zero acts as one; part of the port disabled
		set_config(8'd0, 8'hA5);
		run_bursts(30);

		// threshold one, alternating FF/00 samples; receiver holds off long
		set_config(8'd1, 8'hFF);
		hold_ticket = hold_ticket + 1;
		for (int i = 0; i < 20; i++)
			send_sample(MODE_DEBOUNCE, (i % 2) ? 8'h00 : 8'hFF);

		// high threshold on one switch, upper bits disabled and noisy
		set_config(8'd48, 8'h01);
		send_sample(MODE_SNAPSHOT, 8'h00);
		repeat (48) send_sample(MODE_DEBOUNCE, {PORT_BITS'($urandom) | PORT_BITS'(1)});
		send_sample(MODE_DEBOUNCE, 8'h01);

		// everything disabled: no change words at all
		set_config(8'd1, 8'h00);
		run_bursts(10);

		// random settings
		repeat (3) begin
			set_config(CFG_DATA_W'($urandom_range(2, 8)), CFG_DATA_W'($urandom_range(1, 255)));
			run_bursts(15);
		end

		// closing stretch with no idling on either side
		set_config(8'd3, 8'hFF);
		idle_on = 1'b0;
		run_bursts(30);

		settle();
		book.flush_leftover();
		if (book.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
